@@ rtl/trbd_pkg.sv @@
// trbd_pkg: shared types and codes of the telemetry record bit decoder
// result entry layout, result kinds, value kinds, timestamp prefix codes
// no dependencies
`default_nettype none

package trbd_pkg;

  // default sizes handed to the top level
  localparam int unsigned ID_OFFSET_BITS_DEF = 12;
  localparam int unsigned IN_DEPTH_DEF       = 2;
  localparam int unsigned OUT_DEPTH_DEF      = 4;

  // wide timestamp delta that marks the end of the stream
  localparam logic [9:0] END_CODE = 10'd1023;

  // result kinds
  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  // value kinds
  localparam logic [1:0] VK_ZERO   = 2'd0;
  localparam logic [1:0] VK_ONE    = 2'd1;
  localparam logic [1:0] VK_STRING = 2'd2;

  // timestamp prefix codes
  localparam logic [1:0] PFX_SAME  = 2'b00;
  localparam logic [1:0] PFX_INC   = 2'b01;
  localparam logic [1:0] PFX_SMALL = 2'b10;
  localparam logic [1:0] PFX_WIDE  = 2'b11;

  // one result entry as it travels through the result queue
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] timestamp;
    logic [31:0] ident;
    logic [1:0]  value_kind;
    logic [7:0]  text_length;
    logic [7:0]  text_byte;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/trbd_fifo.sv @@
// trbd_fifo: small register queue used for the byte front and the result back
// plain bit-vector payload; no package dependency
`default_nettype none

module trbd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (!do_wr && do_rd) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/trbd_unpack.sv @@
// trbd_unpack: bit window, refilled as it empties, field assembly and record decode
// depends on trbd_pkg (result entry and codes)
`default_nettype none

module trbd_unpack #(
  parameter int unsigned ID_OFFSET_BITS = trbd_pkg::ID_OFFSET_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [31:0]   base_ident,
  input  wire logic          byte_valid,
  input  wire logic [7:0]    byte_data,
  output logic               byte_pop,
  input  wire logic          res_full,
  output logic               res_push,
  output trbd_pkg::res_t     res_data
);

  import trbd_pkg::*;

  // field being assembled
  typedef enum logic [8:0] {
    PH_FIRST_TS = 9'b000000001,
    PH_ID_OFF   = 9'b000000010,
    PH_TAG      = 9'b000000100,
    PH_STR_LEN  = 9'b000001000,
    PH_STR_CHAR = 9'b000010000,
    PH_PREFIX   = 9'b000100000,
    PH_SMALL10  = 9'b001000000,
    PH_SMALL3   = 9'b010000000,
    PH_ID_FLAG  = 9'b100000000
  } phase_t;

  function automatic logic [5:0] field_need(input phase_t ph);
    logic [5:0] n;
    unique case (ph)
      PH_FIRST_TS: n = 6'd32;
      PH_ID_OFF:   n = 6'(ID_OFFSET_BITS);
      PH_TAG:      n = 6'd2;
      PH_STR_LEN:  n = 6'd8;
      PH_STR_CHAR: n = 6'd8;
      PH_PREFIX:   n = 6'd2;
      PH_SMALL10:  n = 6'd10;
      PH_SMALL3:   n = 6'd3;
      default:     n = 6'd1;
    endcase
    return n;
  endfunction

  phase_t      phase_r, phase_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] ts_r, ts_nxt;
  logic [31:0] ident_r, ident_nxt;
  logic [7:0]  chars_r, chars_nxt;
  logic        done_r, done_nxt;
  logic [7:0]  win_bits_r, win_bits_nxt;
  logic [3:0]  win_cnt_r, win_cnt_nxt;
  res_t        pend_r, pend_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  logic        pend_last_r, pend_last_nxt;

  logic        go, fin, new_res, end_seen, byte_end;
  logic [5:0]  need, rem, avail, take;
  logic [8:0]  mask9;
  logic [31:0] ins, v;
  logic [3:0]  win_left, win_after;
  logic [7:0]  chars_m1;
  logic [31:0] ts_addend;
  logic        ts_upd;
  res_t        new_entry;

  // bit extraction from the window into the field accumulator
  always_comb begin
    go       = (win_cnt_r != 4'd0) && !(pend_valid_r && res_full) && !done_r;
    need     = field_need(phase_r);
    rem      = need - {1'b0, cnt_r};
    avail    = {2'b00, win_cnt_r};
    take     = (avail < rem) ? avail : rem;
    mask9    = (9'd1 << take[3:0]) - 9'd1;
    ins      = {24'd0, win_bits_r & mask9[7:0]} << cnt_r;
    v        = acc_r | ins;
    fin      = go && (take == rem);
    win_left = win_cnt_r - take[3:0];
    chars_m1 = chars_r - 8'd1;
  end

  // field completion: record decode
  always_comb begin
    phase_nxt = phase_r;
    ident_nxt = ident_r;
    chars_nxt = chars_r;
    done_nxt  = done_r;
    ts_upd    = 1'b0;
    ts_addend = 32'd0;
    ts_nxt    = ts_r;
    new_res   = 1'b0;
    end_seen  = 1'b0;
    new_entry = '{kind: KIND_RECORD, timestamp: ts_r, ident: ident_r,
                  value_kind: VK_ZERO, text_length: 8'd0, text_byte: 8'd0,
                  last: 1'b0};
    if (fin) begin
      unique case (phase_r)
        PH_FIRST_TS: begin
          ts_nxt    = v;
          phase_nxt = PH_ID_OFF;
        end
        PH_ID_OFF: begin
          ident_nxt = base_ident + v;
          phase_nxt = PH_TAG;
        end
        PH_TAG: begin
          if (!v[1]) begin
            new_res              = 1'b1;
            new_entry.value_kind = v[1:0];
            phase_nxt            = PH_PREFIX;
          end else begin
            phase_nxt = PH_STR_LEN;
          end
        end
        PH_STR_LEN: begin
          chars_nxt             = v[7:0];
          new_res               = 1'b1;
          new_entry.value_kind  = VK_STRING;
          new_entry.text_length = v[7:0];
          phase_nxt             = (v[7:0] == 8'd0) ? PH_PREFIX : PH_STR_CHAR;
        end
        PH_STR_CHAR: begin
          chars_nxt             = chars_m1;
          new_res               = 1'b1;
          new_entry.kind        = KIND_CHAR;
          new_entry.value_kind  = VK_STRING;
          new_entry.text_length = chars_m1;
          new_entry.text_byte   = v[7:0];
          if (chars_m1 == 8'd0) begin
            phase_nxt = PH_PREFIX;
          end
        end
        PH_PREFIX: begin
          unique case (v[1:0])
            PFX_INC: begin
              ts_upd    = 1'b1;
              ts_addend = 32'd1;
              phase_nxt = PH_ID_FLAG;
            end
            PFX_SMALL: phase_nxt = PH_SMALL3;
            PFX_WIDE:  phase_nxt = PH_SMALL10;
            default:   phase_nxt = PH_ID_FLAG;
          endcase
        end
        PH_SMALL10: begin
          if (v[9:0] == END_CODE) begin
            done_nxt       = 1'b1;
            end_seen       = 1'b1;
            new_res        = 1'b1;
            new_entry.kind = KIND_END;
          end else begin
            ts_upd    = 1'b1;
            ts_addend = {22'd0, v[9:0]};
            phase_nxt = PH_ID_FLAG;
          end
        end
        PH_SMALL3: begin
          ts_upd    = 1'b1;
          ts_addend = {29'd0, v[2:0]} + 32'd2;
          phase_nxt = PH_ID_FLAG;
        end
        default: begin
          if (!v[0]) begin
            ident_nxt = ident_r + 32'd1;
            phase_nxt = PH_TAG;
          end else begin
            phase_nxt = PH_ID_OFF;
          end
        end
      endcase
    end
    if (ts_upd) begin
      ts_nxt = ts_r + ts_addend;
    end
  end

  // accumulator and window refill
  always_comb begin
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    win_bits_nxt = win_bits_r;
    win_cnt_nxt  = win_cnt_r;
    byte_pop     = 1'b0;
    byte_end     = go && ((win_left == 4'd0) || end_seen);
    if (go) begin
      win_bits_nxt = win_bits_r >> take[3:0];
      win_cnt_nxt  = win_left;
      if (fin) begin
        acc_nxt = 32'd0;
        cnt_nxt = 5'd0;
      end else begin
        acc_nxt = v;
        cnt_nxt = cnt_r + take[4:0];
      end
    end
    win_after = win_cnt_nxt;
    if (done_r) begin
      // after the end marker every byte is dropped
      win_cnt_nxt = 4'd0;
      byte_pop    = byte_valid;
    end else if (win_after == 4'd0 && byte_valid) begin
      win_bits_nxt = byte_data;
      win_cnt_nxt  = 4'd8;
      byte_pop     = 1'b1;
    end
  end

  // one-entry hold so the final result of a byte can be flagged
  always_comb begin
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    pend_last_nxt  = pend_last_r;
    res_push       = 1'b0;
    res_data       = pend_r;
    res_data.last  = pend_last_r;
    if (go) begin
      if (new_res) begin
        res_push       = pend_valid_r;
        pend_nxt       = new_entry;
        pend_valid_nxt = 1'b1;
        pend_last_nxt  = byte_end;
      end else if (pend_valid_r && (pend_last_r || byte_end)) begin
        res_push       = 1'b1;
        res_data.last  = 1'b1;
        pend_valid_nxt = 1'b0;
      end
    end else if (pend_valid_r && pend_last_r && !res_full) begin
      res_push       = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FIRST_TS;
      acc_r        <= '0;
      cnt_r        <= '0;
      ts_r         <= '0;
      ident_r      <= '0;
      chars_r      <= '0;
      done_r       <= 1'b0;
      win_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
      pend_last_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      acc_r        <= acc_nxt;
      cnt_r        <= cnt_nxt;
      ts_r         <= ts_nxt;
      ident_r      <= ident_nxt;
      chars_r      <= chars_nxt;
      done_r       <= done_nxt;
      win_cnt_r    <= win_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_last_r  <= pend_last_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    win_bits_r <= win_bits_nxt;
    pend_r     <= pend_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/telemetry_record_bit_decoder.sv @@
// Telemetry record bit decoder. Data-section bytes go in through a queue-style
// port (push/full) and are unpacked least significant bit first into records
// and string characters, which come out through a queue-style port
// (empty/pop), one result per transfer, with last set on the final result a
// byte causes. A byte queue feeds the unpacker, which works through one run of
// bits per cycle, a run ending where a field completes or where the byte runs
// out. A byte thus takes one run per field it completes, plus one when bits
// toward the next field are left over; bytes inside a long field (the first
// timestamp, a string character) stream at one byte per cycle. The unpacker
// also waits while its held result cannot enter a full result queue. Results
// leave the result queue one per cycle when popped. A result passes from its
// byte through the byte queue, the bit window, a one-entry hold and the result
// queue, and it waits longer when the byte still has runs to work through or
// earlier bytes are still being unpacked. base_ident is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle,
// which the block itself does not enforce. After the end marker all bytes are
// taken and dropped until reset.
// depends on trbd_pkg, trbd_fifo, trbd_unpack
`default_nettype none

module telemetry_record_bit_decoder #(
  parameter int unsigned ID_OFFSET_BITS = trbd_pkg::ID_OFFSET_BITS_DEF,
  parameter int unsigned IN_DEPTH       = trbd_pkg::IN_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH      = trbd_pkg::OUT_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // byte input
  input  wire logic               push,
  input  wire logic [7:0]         in_data_byte,
  output logic                    full,
  // result output
  output logic                    empty,
  input  wire logic               pop,
  output logic [1:0]              out_kind,
  output logic signed [31:0]      out_timestamp,
  output logic [31:0]             out_ident,
  output logic [1:0]              out_value_kind,
  output logic [7:0]              out_text_length,
  output logic [7:0]              out_text_byte,
  output logic                    out_last,
  // configuration
  input  wire logic               cfg_wr_en,
  input  wire logic [31:0]        cfg_wr_data
);

  import trbd_pkg::*;

  logic [31:0] base_ident_r;
  logic        byte_empty, byte_pop;
  logic [7:0]  byte_data;
  logic        res_full, res_push;
  res_t        res_wr, res_rd;

  // base id register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_ident_r <= '0;
    end else if (cfg_wr_en) begin
      base_ident_r <= cfg_wr_data;
    end
  end

  // front: byte queue
  trbd_fifo #(
    .WIDTH (8),
    .DEPTH (IN_DEPTH)
  ) u_in_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (in_data_byte),
    .full    (full),
    .rd_en   (byte_pop),
    .rd_data (byte_data),
    .empty   (byte_empty)
  );

  // back: unpacking and record decode
  trbd_unpack #(
    .ID_OFFSET_BITS (ID_OFFSET_BITS)
  ) u_unpack (
    .clk        (clk),
    .rst_n      (rst_n),
    .base_ident (base_ident_r),
    .byte_valid (!byte_empty),
    .byte_data  (byte_data),
    .byte_pop   (byte_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_wr)
  );

  // result queue
  trbd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  // result fields
  assign out_kind        = res_rd.kind;
  assign out_timestamp   = res_rd.timestamp;
  assign out_ident       = res_rd.ident;
  assign out_value_kind  = res_rd.value_kind;
  assign out_text_length = res_rd.text_length;
  assign out_text_byte   = res_rd.text_byte;
  assign out_last        = res_rd.last;

endmodule

`default_nettype wire

@@ dv/telemetry_record_bit_decoder_tb.sv @@
// telemetry_record_bit_decoder_tb: self-checking bench for the telemetry record bit decoder
// drives packed data-section bytes, predicts every record, character and end result
// depends on trbd_pkg and telemetry_record_bit_decoder
`default_nettype none

module telemetry_record_bit_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned DIR_ROWS      = 23;

  // decoder field being collected
  typedef enum logic [3:0] {
    F_FIRST_TS, F_ID_OFF, F_TAG, F_STR_LEN, F_STR_CHAR,
    F_PREFIX, F_SMALL10, F_SMALL3, F_ID_FLAG
  } field_t;

  // one directed byte, with a hand-written expectation where it is obvious
  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    res_t       exp;
  } stim_row_t;

  // directed stream: first record at the top timestamp, +1 wrap to zero, all prefixes,
  // both id flags, all four tags, empty string, three-character string, cut mid-record
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h5F, 1'b1, '{KIND_RECORD, 32'hFFFF_FFFF, 32'h0000_0FFF, VK_ONE, 8'd0, 8'd0, 1'b1}},
    '{8'h20, 1'b1, '{KIND_RECORD, 32'h0000_0000, 32'h0000_1000, VK_ZERO, 8'd0, 8'd0, 1'b1}},
    '{8'h00, 1'b0, '0},
    '{8'h08, 1'b0, '0},
    '{8'hE0, 1'b1, '{KIND_RECORD, 32'h0000_0000, 32'h0000_0000, VK_STRING, 8'd0, 8'd0, 1'b1}},
    '{8'h3D, 1'b0, '0},
    '{8'h10, 1'b0, '0},
    '{8'h04, 1'b0, '0},
    '{8'hF0, 1'b0, '0},
    '{8'hBF, 1'b1, '{KIND_CHAR, 32'h0000_0009, 32'h0000_0001, VK_STRING, 8'd0, 8'hFF, 1'b1}},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h9F, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h90, 1'b0, '0},
    '{8'h60, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h20, 1'b0, '0}
  };

  // dut ports; the inputs driven by the bench are known from time zero
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic [7:0]        in_data_byte = 8'd0;
  logic              full;
  logic              empty;
  logic              pop = 1'b0;
  logic [1:0]        out_kind;
  logic signed [31:0] out_timestamp;
  logic [31:0]       out_ident;
  logic [1:0]        out_value_kind;
  logic [7:0]        out_text_length;
  logic [7:0]        out_text_byte;
  logic              out_last;
  logic              cfg_wr_en = 1'b0;
  logic [31:0]       cfg_wr_data = 32'd0;

  // decoder shadow state
  field_t      phase = F_FIRST_TS;
  logic [31:0] field_acc = '0;
  int unsigned field_bits = 0;
  logic [31:0] cur_ts = '0;
  logic [31:0] cur_id = '0;
  logic [7:0]  chars_left = '0;
  logic        stream_ended = 1'b0;
  logic [31:0] base_id = '0;

  // results of the byte being decoded, and the results still owed by the dut
  res_t byte_results [$];
  res_t pending_results [$];

  // stream builder and bookkeeping
  logic        pend_bits [$];
  logic        row_typed = 1'b0;
  res_t        row_exp = '0;
  logic        force_long = 1'b0;
  logic        rcv_hold = 1'b0;
  int unsigned snd_idle = 0;
  int unsigned rcv_idle = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned bytes_taken = 0;
  int unsigned errors = 0;
  int unsigned seen_records = 0;
  int unsigned seen_chars = 0;
  int unsigned seen_ends = 0;

  telemetry_record_bit_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .in_data_byte   (in_data_byte),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .out_kind       (out_kind),
    .out_timestamp  (out_timestamp),
    .out_ident      (out_ident),
    .out_value_kind (out_value_kind),
    .out_text_length(out_text_length),
    .out_text_byte  (out_text_byte),
    .out_last       (out_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: pop at random unless held off
  always @(negedge clk) begin
    pop <= !rcv_hold && ($urandom_range(99) >= rcv_idle);
  end

  // append one result built from the current record state, keeping at most three per byte
  function automatic void add_result(input logic [1:0] kind, input logic [1:0] vkind,
                                     input logic [7:0] tlen, input logic [7:0] tbyte);
    res_t r;
    if (byte_results.size() < 3) begin
      r = '{kind, cur_ts, cur_id, vkind, tlen, tbyte, 1'b0};
      byte_results.insert(byte_results.size(), r);
    end
  endfunction

  // act on one completed field
  function automatic void complete_field(input logic [31:0] v);
    case (phase)
      F_FIRST_TS: begin
        cur_ts = v;
        phase = F_ID_OFF;
      end
      F_ID_OFF: begin
        cur_id = base_id + v;
        phase = F_TAG;
      end
      F_TAG: begin
        if (v < 32'(VK_STRING)) begin
          add_result(KIND_RECORD, v[1:0], 8'd0, 8'd0);
          phase = F_PREFIX;
        end else begin
          phase = F_STR_LEN;
        end
      end
      F_STR_LEN: begin
        chars_left = v[7:0];
        add_result(KIND_RECORD, VK_STRING, chars_left, 8'd0);
        phase = (chars_left == 8'd0) ? F_PREFIX : F_STR_CHAR;
      end
      F_STR_CHAR: begin
        chars_left = chars_left - 8'd1;
        add_result(KIND_CHAR, VK_STRING, chars_left, v[7:0]);
        if (chars_left == 8'd0) phase = F_PREFIX;
      end
      F_PREFIX: begin
        case (v[1:0])
          PFX_INC: begin
            cur_ts = cur_ts + 32'd1;
            phase = F_ID_FLAG;
          end
          PFX_SMALL: phase = F_SMALL3;
          PFX_WIDE:  phase = F_SMALL10;
          default:   phase = F_ID_FLAG;
        endcase
      end
      F_SMALL10: begin
        if (v == {22'd0, END_CODE}) begin
          stream_ended = 1'b1;
          add_result(KIND_END, VK_ZERO, 8'd0, 8'd0);
        end else begin
          cur_ts = cur_ts + v;
          phase = F_ID_FLAG;
        end
      end
      F_SMALL3: begin
        cur_ts = cur_ts + v + 32'd2;
        phase = F_ID_FLAG;
      end
      default: begin
        if (v == 32'd0) begin
          cur_id = cur_id + 32'd1;
          phase = F_TAG;
        end else begin
          phase = F_ID_OFF;
        end
      end
    endcase
  endfunction

  // unpack one byte lsb first into byte_results
  function automatic void decode_byte(input logic [7:0] b);
    int unsigned need;
    int          i;
    logic [31:0] v;
    byte_results.delete();
    for (i = 0; i < 8 && !stream_ended; i++) begin
      case (phase)
        F_FIRST_TS:            need = 32;
        F_ID_OFF:              need = 12;
        F_TAG, F_PREFIX:       need = 2;
        F_STR_LEN, F_STR_CHAR: need = 8;
        F_SMALL10:             need = 10;
        F_SMALL3:              need = 3;
        default:               need = 1;
      endcase
      if (field_bits < 32) field_acc[field_bits] = b[i];
      field_bits++;
      if (field_bits >= need) begin
        v = field_acc;
        field_acc = '0;
        field_bits = 0;
        complete_field(v);
      end
    end
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // transfer monitor: predict on accepted bytes, check accepted results
  always @(posedge clk) begin
    res_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("Regression FAIL");
      $finish;
    end else if (rst_n) begin
      if (cfg_wr_en) base_id = cfg_wr_data;
      if (push && !full) begin
        bytes_taken++;
        decode_byte(in_data_byte);
        if (row_typed) pending_results.insert(pending_results.size(), row_exp);
        else foreach (byte_results[k])
          pending_results.insert(pending_results.size(), byte_results[k]);
      end
      if (pop && !empty) begin
        case (out_kind)
          KIND_RECORD: seen_records++;
          KIND_CHAR:   seen_chars++;
          default:     seen_ends++;
        endcase
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, kind %0h ts %0h id %0h", $time, out_kind,
                   out_timestamp, out_ident);
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_kind));
          check_field("timestamp", want.timestamp, out_timestamp);
          check_field("ident", want.ident, out_ident);
          check_field("value_kind", 32'(want.value_kind), 32'(out_value_kind));
          check_field("text_length", 32'(want.text_length), 32'(out_text_length));
          check_field("text_byte", 32'(want.text_byte), 32'(out_text_byte));
          check_field("last", 32'(want.last), 32'(out_last));
        end
      end
    end
  end

  // offer one byte, with random gaps, and wait for its transfer
  task automatic send_byte(input logic [7:0] b, input logic typed, input res_t exp);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push         <= 1'b1;
    in_data_byte <= b;
    row_typed    <= typed;
    row_exp      <= exp;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  // stop offering, wait for every owed result, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // append a field to the bit stream, lsb first
  task automatic put_field(input logic [31:0] v, input int unsigned width);
    int unsigned k;
    for (k = 0; k < width; k++) pend_bits.insert(pend_bits.size(), v[k]);
  endtask

  // send every complete byte of the bit stream
  task automatic flush_bytes();
    logic [7:0] b;
    int         k;
    while (pend_bits.size() >= 8) begin
      for (k = 0; k < 8; k++) b[k] = pend_bits.pop_front();
      send_byte(b, 1'b0, '0);
    end
  endtask

  function automatic logic [31:0] pick_char();
    case ($urandom_range(7))
      0:       return 32'h00;
      1:       return 32'hFF;
      default: return 32'($urandom_range(255));
    endcase
  endfunction

  // id flag, optional offset, value tag and optional string
  task automatic put_record_body();
    logic [1:0]  tag;
    int unsigned len;
    if ($urandom_range(1) == 1) begin
      put_field(32'd1, 1);
      case ($urandom_range(7))
        0:       put_field(32'h000, 12);
        1:       put_field(32'hFFF, 12);
        default: put_field(32'($urandom_range(4095)), 12);
      endcase
    end else begin
      put_field(32'd0, 1);
    end
    tag = 2'($urandom_range(3));
    put_field(32'(tag), 2);
    if (tag >= VK_STRING) begin
      if (force_long) begin
        len = 255;
        force_long = 1'b0;
      end else if ($urandom_range(29) == 0) begin
        len = $urandom_range(40, 7);
      end else begin
        len = $urandom_range(6);
      end
      put_field(32'(len), 8);
      repeat (len) put_field(pick_char(), 8);
    end
  endtask

  // later record: timestamp prefix and delta, then the body
  task automatic put_record();
    logic [1:0] prefix;
    prefix = 2'($urandom_range(3));
    put_field(32'(prefix), 2);
    case (prefix)
      PFX_SMALL: put_field(32'($urandom_range(7)), 3);
      PFX_WIDE: begin
        case ($urandom_range(3))
          0:       put_field(32'd0, 10);
          1:       put_field(32'd1022, 10);
          default: put_field(32'($urandom_range(1022)), 10);
        endcase
      end
      default: ;
    endcase
    put_record_body();
  endtask

  task automatic run_records(input int unsigned budget);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      put_record();
      flush_bytes();
    end
  endtask

  initial begin
    int unsigned i;
    // hold reset, then release it
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_base(32'h0000_0000);

    // directed table, receiver idles more than sender
    snd_idle = 38;
    rcv_idle = 47;
    for (i = 0; i < DIR_ROWS; i++) send_byte(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].exp);
    drain();

    // random records with the top base, continuing the record cut off above
    write_base(32'hFFFF_FFFF);
    put_record_body();
    run_records(120);
    drain();

    // sender idles more, one full-length string
    snd_idle = 47;
    rcv_idle = 38;
    write_base(32'h8000_0000);
    force_long = 1'b1;
    run_records(150);
    drain();

    // back to back transfers
    snd_idle = 0;
    rcv_idle = 0;
    write_base($urandom);
    run_records(100);
    drain();

    // receiver held off while bytes keep coming
    fork
      begin
        rcv_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rcv_hold = 1'b0;
      end
      run_records(40);
    join
    drain();

    // end marker, then bytes that must be dropped
    snd_idle = 20;
    rcv_idle = 20;
    run_records(20);
    put_field(32'(PFX_WIDE), 2);
    put_field(32'(END_CODE), 10);
    while (pend_bits.size() % 8 != 0) pend_bits.insert(pend_bits.size(), 1'($urandom_range(1)));
    flush_bytes();
    repeat (6) send_byte(8'($urandom_range(255)), 1'b0, '0);
    drain();

    $display("covered %0d bytes in, %0d records, %0d string characters, %0d end markers",
             bytes_taken, seen_records, seen_chars, seen_ends);
    $display("four base settings, four idle mixes and one long receiver hold-off");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/trbd_pkg.sv
rtl/trbd_fifo.sv
rtl/trbd_unpack.sv
rtl/telemetry_record_bit_decoder.sv
dv/telemetry_record_bit_decoder_tb.sv
